FILE: rtl/btlpm_pkg.sv
// Shared types and constants for the binary trie route table.
`default_nettype none
package btlpm_pkg;

  localparam int NODE_COUNT = 4096;
  localparam int ADDR_BITS  = 32;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(NODE_COUNT + 1);
  localparam int LVL_W  = $clog2(ADDR_BITS + 1);
  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int HOP_W  = 32;
  localparam int PORT_W = 8;

  localparam logic [CNT_W-1:0] NODE_COUNT_C = CNT_W'(NODE_COUNT);
  localparam logic [LVL_W-1:0] ADDR_BITS_LVL = LVL_W'(ADDR_BITS);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [NODE_W-1:0] c0;
    logic [NODE_W-1:0] c1;
    logic              has_route;
  } node_t;

  typedef struct packed {
    logic [HOP_W-1:0]  hop;
    logic [PORT_W-1:0] port;
  } route_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    node_t             wr_data;
  } node_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    route_t            wr_data;
  } route_req_t;

  typedef struct packed {
    logic              hit;
    logic [HOP_W-1:0]  gateway;
    logic [PORT_W-1:0] port;
    logic              full;
  } res_t;

endpackage
`default_nettype wire

FILE: rtl/btlpm_if.sv
// Valid/ready channel interfaces for request and result beats.
`default_nettype none
interface btlpm_in_if import btlpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;
  logic [LEN_W-1:0]  prefix_len;
  logic [HOP_W-1:0]  gateway;
  logic [PORT_W-1:0] out_port;

  modport source (output valid, op, address, prefix_len, gateway, out_port, input ready);
  modport sink   (input valid, op, address, prefix_len, gateway, out_port, output ready);
endinterface

interface btlpm_out_if import btlpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [HOP_W-1:0]  route_next_hop;
  logic [PORT_W-1:0] route_port;
  logic              table_full;

  modport source (output valid, hit, route_next_hop, route_port, table_full, input ready);
  modport sink   (input valid, hit, route_next_hop, route_port, table_full, output ready);
endinterface
`default_nettype wire

FILE: rtl/btlpm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none
module btlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/btlpm_walker.sv
// Trie walk sequencer: one node read per level, insert allocation, lookup match.
`default_nettype none
module btlpm_walker import btlpm_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  btlpm_in_if.sink    in_ch,
  output node_req_t   node_req,
  input  wire node_t  node_rd,
  output route_req_t  route_req,
  input  wire route_t route_rd,
  output logic        res_valid,
  output res_t        res,
  input  wire logic   res_ready
);

  st_t                state_r, state_nxt;
  logic               op_r, op_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [LVL_W-1:0]   len_r, len_nxt;
  logic [HOP_W-1:0]   hop_r, hop_nxt;
  logic [PORT_W-1:0]  port_r, port_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic               fresh_r, fresh_nxt;
  logic               found_r, found_nxt;
  logic [NODE_W-1:0]  best_r, best_nxt;
  logic               hit_r, hit_nxt;
  logic               full_r, full_nxt;
  logic [CNT_W-1:0]   nodes_used_r, nodes_used_nxt;

  node_t              cur;
  node_t              upd;
  logic               dir;
  logic [NODE_W-1:0]  raw_child;
  logic [NODE_W-1:0]  child;
  logic               has_child;
  logic               pool_full;
  logic               lk_found;
  logic [NODE_W-1:0]  lk_best;
  logic [LVL_W-1:0]   len_sat;

  // a freshly allocated node is known empty and not yet in memory
  assign cur       = fresh_r ? '0 : node_rd;
  assign dir       = addr_r[ADDR_BITS-1];
  assign raw_child = dir ? cur.c1 : cur.c0;
  assign child     = (CNT_W'(raw_child) < NODE_COUNT_C) ? raw_child : '0;
  assign has_child = (child != '0);
  assign pool_full = (nodes_used_r >= NODE_COUNT_C);
  assign lk_found  = found_r | cur.has_route;
  assign lk_best   = cur.has_route ? node_r : best_r;
  assign len_sat   = (in_ch.prefix_len > LEN_W'(ADDR_BITS)) ? ADDR_BITS_LVL
                                                            : LVL_W'(in_ch.prefix_len);

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    upd = cur;
    if (dir) begin
      upd.c1 = nodes_used_r[NODE_W-1:0];
    end else begin
      upd.c0 = nodes_used_r[NODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      nodes_used_r <= CNT_W'(1);
    end else begin
      state_r      <= state_nxt;
      nodes_used_r <= nodes_used_nxt;
    end
    op_r    <= op_nxt;
    addr_r  <= addr_nxt;
    len_r   <= len_nxt;
    hop_r   <= hop_nxt;
    port_r  <= port_nxt;
    level_r <= level_nxt;
    node_r  <= node_nxt;
    fresh_r <= fresh_nxt;
    found_r <= found_nxt;
    best_r  <= best_nxt;
    hit_r   <= hit_nxt;
    full_r  <= full_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    hop_nxt        = hop_r;
    port_nxt       = port_r;
    level_nxt      = level_r;
    node_nxt       = node_r;
    fresh_nxt      = fresh_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    hit_nxt        = hit_r;
    full_nxt       = full_r;
    nodes_used_nxt = nodes_used_r;
    node_req       = '0;
    route_req      = '0;
    res_valid      = 1'b0;

    case (state_r)
      ST_INIT: begin
        // clear the root once after reset
        node_req.wr_en   = 1'b1;
        node_req.wr_addr = '0;
        node_req.wr_data = '0;
        state_nxt        = ST_IDLE;
      end

      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt           = in_ch.op;
          addr_nxt         = in_ch.address[ADDR_BITS-1:0];
          len_nxt          = len_sat;
          hop_nxt          = in_ch.gateway;
          port_nxt         = in_ch.out_port;
          level_nxt        = '0;
          node_nxt         = '0;
          fresh_nxt        = 1'b0;
          found_nxt        = 1'b0;
          best_nxt         = '0;
          node_req.rd_en   = 1'b1;
          node_req.rd_addr = '0;
          state_nxt        = ST_WALK;
        end
      end

      ST_WALK: begin
        if (op_r == OP_LOOKUP) begin
          found_nxt = lk_found;
          best_nxt  = lk_best;
          if (level_r == ADDR_BITS_LVL || !has_child) begin
            route_req.rd_en   = 1'b1;
            route_req.rd_addr = lk_best;
            hit_nxt           = lk_found;
            full_nxt          = 1'b0;
            state_nxt         = ST_DONE;
          end else begin
            node_req.rd_en   = 1'b1;
            node_req.rd_addr = child;
            node_nxt         = child;
            level_nxt        = level_r + LVL_W'(1);
            addr_nxt         = addr_r << 1;
          end
        end else begin
          if (level_r == len_r) begin
            // final node: set the route, keep the children
            node_req.wr_en             = 1'b1;
            node_req.wr_addr           = node_r;
            node_req.wr_data           = cur;
            node_req.wr_data.has_route = 1'b1;
            route_req.wr_en            = 1'b1;
            route_req.wr_addr          = node_r;
            route_req.wr_data          = '{hop: hop_r, port: port_r};
            hit_nxt                    = 1'b0;
            full_nxt                   = 1'b0;
            state_nxt                  = ST_DONE;
          end else if (has_child) begin
            node_req.rd_en   = 1'b1;
            node_req.rd_addr = child;
            node_nxt         = child;
            fresh_nxt        = 1'b0;
            level_nxt        = level_r + LVL_W'(1);
            addr_nxt         = addr_r << 1;
          end else if (pool_full) begin
            // a fresh node still has to land in memory as empty
            node_req.wr_en   = fresh_r;
            node_req.wr_addr = node_r;
            node_req.wr_data = '0;
            hit_nxt          = 1'b0;
            full_nxt         = 1'b1;
            state_nxt        = ST_DONE;
          end else begin
            node_req.wr_en   = 1'b1;
            node_req.wr_addr = node_r;
            node_req.wr_data = upd;
            nodes_used_nxt   = nodes_used_r + CNT_W'(1);
            node_nxt         = nodes_used_r[NODE_W-1:0];
            fresh_nxt        = 1'b1;
            level_nxt        = level_r + LVL_W'(1);
            addr_nxt         = addr_r << 1;
          end
        end
      end

      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.hit     = hit_r;
    res.full    = full_r;
    res.gateway = hit_r ? route_rd.hop : '0;
    res.port    = hit_r ? route_rd.port : '0;
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !node_req.wr_en && !route_req.wr_en)
    else $error("table written while idle");

  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_used_r <= NODE_COUNT_C && nodes_used_r != '0)
    else $error("node pool count out of range");

  a_pool_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> nodes_used_r >= $past(nodes_used_r))
    else $error("node pool count went down");

  a_full_origin: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.full |-> op_r == OP_INSERT && nodes_used_r == NODE_COUNT_C && !res.hit)
    else $error("table full flagged without exhausted pool");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> level_r <= ADDR_BITS_LVL)
    else $error("walk went past the last address bit");

endmodule
`default_nettype wire

FILE: rtl/binary_trie_longest_prefix_match.sv
// Top level: IPv4 longest prefix match route table on a binary trie.
//
//  Channel  Dir  Beat contents
//  in_ch    in   op, address, prefix_len, gateway, out_port
//  out_ch   out  hit, route_next_hop, route_port, table_full
//
// One item is in the walk at a time, with one node memory read per trie
// level walked (at most 32), plus the accept and result states.
// After reset the root node is cleared before in_ch is ready.
// A result waits in the output register; the next beat is accepted then,
// and its walk holds at the end until the output register frees up.
`default_nettype none
module binary_trie_longest_prefix_match import btlpm_pkg::*; (
  input wire logic  clk,
  input wire logic  rst_n,
  btlpm_in_if.sink  in_ch,
  btlpm_out_if.source out_ch
);

  node_req_t  node_req;
  node_t      node_rd;
  route_req_t route_req;
  route_t     route_rd;
  logic       res_valid;
  res_t       res;
  logic       res_ready;

  logic              out_valid_r, out_valid_nxt;
  logic              hit_r;
  logic [HOP_W-1:0]  gateway_r;
  logic [PORT_W-1:0] port_r;
  logic              full_r;

  // walk sequencer: owns the node and route memory accesses
  btlpm_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .node_req  (node_req),
    .node_rd   (node_rd),
    .route_req (route_req),
    .route_rd  (route_rd),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // node memory: child pointers and route-present flag
  btlpm_ram #(
    .WIDTH ($bits(node_t)),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (node_req.wr_en),
    .wr_addr (node_req.wr_addr),
    .wr_data (node_req.wr_data),
    .rd_en   (node_req.rd_en),
    .rd_addr (node_req.rd_addr),
    .rd_data (node_rd)
  );

  // route memory: next hop and port, read at the end of each lookup
  btlpm_ram #(
    .WIDTH ($bits(route_t)),
    .DEPTH (NODE_COUNT)
  ) u_route_ram (
    .clk     (clk),
    .wr_en   (route_req.wr_en),
    .wr_addr (route_req.wr_addr),
    .wr_data (route_req.wr_data),
    .rd_en   (route_req.rd_en),
    .rd_addr (route_req.rd_addr),
    .rd_data (route_rd)
  );

  // output register parts the walk from the result consumer
  assign res_ready = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (res_valid && res_ready) begin
      hit_r     <= res.hit;
      gateway_r <= res.gateway;
      port_r    <= res.port;
      full_r    <= res.full;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.hit            = hit_r;
  assign out_ch.route_next_hop = gateway_r;
  assign out_ch.route_port     = port_r;
  assign out_ch.table_full     = full_r;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(gateway_r) && $stable(hit_r))
    else $error("pending result beat dropped or changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && out_valid_r && !out_ch.ready |-> !res_ready)
    else $error("result would overwrite a pending beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> gateway_r == '0 && port_r == '0)
    else $error("miss result carries route data");

endmodule
`default_nettype wire

FILE: verif/trie_route_checker.sv
// Checker for the route table: predicts every result beat and compares it.
`timescale 1ns / 100ps
module trie_route_checker import btlpm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  btlpm_in_if  in_ch,
  btlpm_out_if out_ch,
  output int   mismatches,
  output int   pending
);

  // Shadow trie; entries above alloc_cnt are never read.
  logic [NODE_W-1:0] zero_child [NODE_COUNT];
  logic [NODE_W-1:0] one_child  [NODE_COUNT];
  logic              route_set  [NODE_COUNT];
  logic [HOP_W-1:0]  route_hop  [NODE_COUNT];
  logic [PORT_W-1:0] route_intf [NODE_COUNT];
  int unsigned       alloc_cnt;

  res_t expected_routes[$];
  int   err_cnt = 0;
  int   result_no = 0;

  assign mismatches = err_cnt;

  task automatic report_mismatch(input string what, input logic [HOP_W-1:0] got,
                                 input logic [HOP_W-1:0] want);
    err_cnt++;
    $display("MISMATCH result %0d %s: got %h, expected %h", result_no, what, got, want);
  endtask

  // Applies one request to the shadow trie and returns the result beat it causes.
  task automatic predict_route(input logic op, input logic [ADDR_W-1:0] addr,
                               input logic [LEN_W-1:0] plen, input logic [HOP_W-1:0] hop,
                               input logic [PORT_W-1:0] port, output res_t r);
    int                depth;
    int                lvl;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] nxt;
    logic [NODE_W-1:0] best;
    logic              found;
    r     = '0;
    node  = '0;
    best  = '0;
    found = 1'b0;
    if (op == OP_INSERT) begin
      depth = (plen > LEN_W'(ADDR_BITS)) ? ADDR_BITS : int'(plen);
      for (lvl = 0; lvl < depth; lvl++) begin
        nxt = addr[ADDR_BITS-1-lvl] ? one_child[node] : zero_child[node];
        if (nxt == '0) begin
          if (alloc_cnt >= NODE_COUNT) begin
            r.full = 1'b1;
            break;
          end
          nxt = NODE_W'(alloc_cnt);
          alloc_cnt++;
          zero_child[nxt] = '0;
          one_child[nxt]  = '0;
          route_set[nxt]  = 1'b0;
          if (addr[ADDR_BITS-1-lvl]) one_child[node] = nxt;
          else zero_child[node] = nxt;
        end
        node = nxt;
      end
      if (!r.full) begin
        route_set[node]  = 1'b1;
        route_hop[node]  = hop;
        route_intf[node] = port;
      end
    end else begin
      found = route_set[0];
      for (lvl = 0; lvl < ADDR_BITS; lvl++) begin
        nxt = addr[ADDR_BITS-1-lvl] ? one_child[node] : zero_child[node];
        if (nxt == '0) break;
        node = nxt;
        if (route_set[node]) begin
          found = 1'b1;
          best  = node;
        end
      end
      if (found) begin
        r.hit     = 1'b1;
        r.gateway = route_hop[best];
        r.port    = route_intf[best];
      end
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    res_t pred;
    if (!rst_n) begin
      zero_child[0] = '0;
      one_child[0]  = '0;
      route_set[0]  = 1'b0;
      alloc_cnt     = 1;
      expected_routes.delete();
    end else begin
      // results first: a beat can never answer a request taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got.hit     = out_ch.hit;
        got.gateway = out_ch.route_next_hop;
        got.port    = out_ch.route_port;
        got.full    = out_ch.table_full;
        if (expected_routes.size() == 0) begin
          report_mismatch("unexpected beat, next hop", got.gateway, '0);
        end else begin
          want = expected_routes.pop_front();
          if (got.hit !== want.hit) report_mismatch("hit", HOP_W'(got.hit), HOP_W'(want.hit));
          if (got.gateway !== want.gateway)
            report_mismatch("route_next_hop", got.gateway, want.gateway);
          if (got.port !== want.port)
            report_mismatch("route_port", HOP_W'(got.port), HOP_W'(want.port));
          if (got.full !== want.full)
            report_mismatch("table_full", HOP_W'(got.full), HOP_W'(want.full));
        end
        result_no++;
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_route(in_ch.op, in_ch.address, in_ch.prefix_len, in_ch.gateway,
                      in_ch.out_port, pred);
        expected_routes.push_back(pred);
      end
    end
    pending <= expected_routes.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top: clock, reset, request stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps
module tb_top;
  import btlpm_pkg::*;

  // Slowest item is a full 32-level walk plus stalls on both sides; the limit is
  // many times the worst expected run of roughly 1050 items.
  localparam int CYCLE_LIMIT  = 400000;
  // Walk of a full 32-level item plus accept and result cycles, with margin.
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  plen;
  } prefix_t;

  logic clk;
  logic rst_n;

  btlpm_in_if  in_ch();
  btlpm_out_if out_ch();

  int mismatches;
  int pending;

  // Knobs shared by the stimulus and the receiver process.
  int          snd_idle_pct  = 0;
  int          rcv_stall_pct = 0;
  int          hold_cycles   = 0;
  int unsigned cycle_cnt     = 0;

  // A few route "regions": their upper 16 bits are shared by most inserts,
  // so the trie grows slowly and lookups land on real routes.
  logic [ADDR_W-1:0] route_bases [8];
  prefix_t           known_prefixes [$];

  binary_trie_longest_prefix_match DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  trie_route_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down here when the
  // stimulus asks for one (that backs the block up until in_ch stalls).
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  // One request beat. Valid is only dropped when an idle gap is taken, so it
  // never gets two updates in the same step.
  task automatic send_route_req(input logic op, input logic [ADDR_W-1:0] addr,
                                input logic [LEN_W-1:0] plen, input logic [HOP_W-1:0] hop,
                                input logic [PORT_W-1:0] port);
    prefix_t p;
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.address    <= addr;
    in_ch.prefix_len <= plen;
    in_ch.gateway    <= hop;
    in_ch.out_port   <= port;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_INSERT) begin
      p.addr = addr;
      p.plen = plen;
      known_prefixes.push_back(p);
      if (known_prefixes.size() > 64) void'(known_prefixes.pop_front());
    end
  endtask

  function automatic prefix_t pick_prefix();
    prefix_t p;
    if (known_prefixes.size() == 0) begin
      p.addr = $urandom;
      p.plen = LEN_W'($urandom_range(1, 32));
    end else begin
      p = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
    end
    return p;
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    int s;
    s = $urandom_range(99);
    if (s < 85) return LEN_W'($urandom_range(1, 24));
    if (s < 93) return LEN_W'($urandom_range(25, 32));
    return LEN_W'($urandom_range(33, 63));   // overlong, saturates
  endfunction

  // fill_mode: mostly full-length inserts at random addresses to drain the pool.
  task automatic random_item(input bit fill_mode);
    int                r;
    prefix_t           p;
    logic [ADDR_W-1:0] region;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  plen;
    logic [HOP_W-1:0]  hop;
    logic [PORT_W-1:0] port;
    r      = $urandom_range(99);
    p      = pick_prefix();
    region = route_bases[$urandom_range(7)];
    addr   = {region[31:16], 16'($urandom)};
    plen   = random_len();
    hop    = $urandom;
    port   = PORT_W'($urandom);
    if (fill_mode) begin
      if (r < 55) begin
        plen = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(33, 63)) : LEN_W'(32);
        send_route_req(OP_INSERT, $urandom, plen, hop, port);
      end else if (r < 70) begin
        send_route_req(OP_INSERT, addr, plen, hop, port);
      end else begin
        send_route_req(OP_LOOKUP, p.addr ^ ($urandom >> $urandom_range(8, 32)),
                       plen, hop, port);
      end
    end else begin
      if (r < 40) begin
        send_route_req(OP_INSERT, addr, plen, hop, port);
      end else if (r < 48) begin
        // same prefix again: the stored route gets replaced
        send_route_req(OP_INSERT, p.addr, p.plen, hop, port);
      end else if (r < 85) begin
        // near a known prefix: flipping only low bits keeps varied match depths
        send_route_req(OP_LOOKUP, p.addr ^ ($urandom >> $urandom_range(8, 32)),
                       plen, hop, port);
      end else if (r < 93) begin
        send_route_req(OP_LOOKUP, addr, plen, hop, port);
      end else begin
        send_route_req(OP_LOOKUP, $urandom, plen, hop, port);
      end
    end
  endtask

  initial begin
    int ph;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_INSERT;
    in_ch.address    <= '0;
    in_ch.prefix_len <= '0;
    in_ch.gateway    <= '0;
    in_ch.out_port   <= '0;
    rst_n            <= 1'b0;
    foreach (route_bases[i]) route_bases[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed part, no idling on either side ----
    // empty table: both lookups miss
    send_route_req(OP_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 8'h00);
    send_route_req(OP_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 8'hFF);
    // nested /8, /16, /32 and longest-match picks among them
    send_route_req(OP_INSERT, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF, 8'hFF);
    send_route_req(OP_INSERT, 32'h0A01_0000, 6'd16, 32'h0000_0000, 8'h00);
    send_route_req(OP_INSERT, 32'h0A01_0203, 6'd32, 32'h1234_5678, 8'h5A);
    send_route_req(OP_LOOKUP, 32'h0A01_0203, 6'd0, 32'h0, 8'h00);
    send_route_req(OP_LOOKUP, 32'h0A01_0204, 6'd0, 32'h0, 8'h00);
    send_route_req(OP_LOOKUP, 32'h0A02_0000, 6'd0, 32'h0, 8'h00);
    send_route_req(OP_LOOKUP, 32'h0B00_0000, 6'd0, 32'h0, 8'h00);
    // replacing the /16 route
    send_route_req(OP_INSERT, 32'h0A01_0000, 6'd16, 32'hA5A5_A5A5, 8'h81);
    send_route_req(OP_LOOKUP, 32'h0A01_FFFF, 6'd0, 32'h0, 8'h00);
    // overlong prefix lengths saturate to a full-length route
    send_route_req(OP_INSERT, 32'hFFFF_FFFF, 6'd33, 32'h5555_5555, 8'hAA);
    send_route_req(OP_INSERT, 32'h8000_0001, 6'd63, 32'hAAAA_AAAA, 8'h55);
    send_route_req(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 8'h00);
    send_route_req(OP_LOOKUP, 32'h8000_0001, 6'd0, 32'h0, 8'h00);
    // deep walk through route-less nodes, stops at the missing last child
    send_route_req(OP_LOOKUP, 32'h8000_0000, 6'd0, 32'h0, 8'h00);
    // /32 under a /1: walk stops at a missing child, falls back to the /1
    send_route_req(OP_INSERT, 32'h0000_0000, 6'd32, 32'h0000_0001, 8'h01);
    send_route_req(OP_INSERT, 32'h0000_0000, 6'd1, 32'h0000_0002, 8'h02);
    send_route_req(OP_LOOKUP, 32'h0000_0001, 6'd0, 32'h0, 8'h00);
    send_route_req(OP_LOOKUP, 32'h7FFF_FFFF, 6'd0, 32'h0, 8'h00);
    // bits past the prefix length are ignored
    send_route_req(OP_INSERT, 32'hC0FF_EE00, 6'd4, 32'h0000_0003, 8'h03);
    send_route_req(OP_LOOKUP, 32'hCFFF_FFFF, 6'd0, 32'h0, 8'h00);

    // ---- random part, one idling mix per phase ----
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 51; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 51; end
        default: begin snd_idle_pct = 25; rcv_stall_pct = 25; end
      endcase
      repeat (210) random_item(1'b0);
    end

    // Back-pressure: receiver holds off while beats keep coming, so the
    // result register fills, the walk parks and in_ch drops ready.
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_cycles   = 300;
    repeat (30) random_item(1'b0);

    // Sender pause until the block has handed back every result.
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    // Fill phase. The default route goes in here, since after it no lookup
    // can miss; then long random inserts run the node pool dry, after which
    // inserts that need a new node report table_full.
    snd_idle_pct  = 25;
    rcv_stall_pct = 25;
    send_route_req(OP_INSERT, $urandom, 6'd0, $urandom, PORT_W'($urandom));
    repeat (150) random_item(1'b1);

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
